### design/assert_macros.svh
// Assertion macros for the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/rcss_pkg.sv
`default_nettype none

package rcss_pkg;

    localparam int FRAC_BITS_DEF  = 8;
    localparam int ALPHA_BITS_DEF = 16;

    localparam int WIDTH_W    = 16;
    localparam int SUM_W      = 18;
    localparam int CENTER_W   = 12;
    localparam int ALPHA_W    = 16;
    localparam int DIFF_W     = 13;
    localparam int DIVISOR_W  = 9;
    localparam int MUL_W      = 6;
    localparam int BOUND_W    = 12;
    localparam int APB_AW     = 5;
    localparam int APB_DW     = 32;
    localparam int CMD_RP_W   = 13;
    localparam int CMD_Y_W    = 14;
    localparam int CMD_T_W    = 18;

    localparam int DIV_CMD = 500;
    localparam int DIV_THR = 10;

    localparam logic [SUM_W-1:0] LOST_LIMIT = 18'd100;

    typedef logic [1:0] chan_t;

    localparam chan_t CH_ROLL     = 2'd0;
    localparam chan_t CH_PITCH    = 2'd1;
    localparam chan_t CH_THROTTLE = 2'd2;
    localparam chan_t CH_YAW      = 2'd3;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_ALPHA           = 3'd0;
    localparam reg_idx_t REG_CENTER_ROLL     = 3'd1;
    localparam reg_idx_t REG_CENTER_PITCH    = 3'd2;
    localparam reg_idx_t REG_CENTER_THROTTLE = 3'd3;
    localparam reg_idx_t REG_CENTER_YAW      = 3'd4;

    localparam logic [ALPHA_W-1:0]  ALPHA_RST           = 16'd52429;
    localparam logic [CENTER_W-1:0] CENTER_ROLL_RST     = 12'd1565;
    localparam logic [CENTER_W-1:0] CENTER_PITCH_RST    = 12'd1492;
    localparam logic [CENTER_W-1:0] CENTER_THROTTLE_RST = 12'd1010;
    localparam logic [CENTER_W-1:0] CENTER_YAW_RST      = 12'd1502;

    typedef struct packed {
        logic [ALPHA_W-1:0]  alpha;
        logic [CENTER_W-1:0] center_roll;
        logic [CENTER_W-1:0] center_pitch;
        logic [CENTER_W-1:0] center_throttle;
        logic [CENTER_W-1:0] center_yaw;
    } cfg_t;

    // Scale of a channel is chan_mul / chan_div applied to the centered width.
    function automatic logic [MUL_W-1:0] chan_mul(input chan_t ch);
        logic [MUL_W-1:0] m;
        case (ch)
            CH_THROTTLE: m = 6'd3;
            CH_YAW:      m = 6'd60;
            default:     m = 6'd32;
        endcase
        return m;
    endfunction

    function automatic logic [DIVISOR_W-1:0] chan_div(input chan_t ch);
        logic [DIVISOR_W-1:0] d;
        case (ch)
            CH_THROTTLE: d = DIVISOR_W'(DIV_THR);
            default:     d = DIVISOR_W'(DIV_CMD);
        endcase
        return d;
    endfunction

    // Centered widths beyond this magnitude all give a saturated scaled value.
    function automatic logic signed [DIFF_W-1:0] chan_dlim(input chan_t ch);
        logic signed [DIFF_W-1:0] l;
        case (ch)
            CH_THROTTLE: l = 13'sd4095;
            CH_YAW:      l = 13'sd256;
            default:     l = 13'sd240;
        endcase
        return l;
    endfunction

    function automatic logic signed [BOUND_W-1:0] chan_lo(input chan_t ch);
        logic signed [BOUND_W-1:0] b;
        case (ch)
            CH_THROTTLE: b = 12'sd0;
            CH_YAW:      b = -12'sd30;
            default:     b = -12'sd15;
        endcase
        return b;
    endfunction

    function automatic logic signed [BOUND_W-1:0] chan_hi(input chan_t ch);
        logic signed [BOUND_W-1:0] b;
        case (ch)
            CH_THROTTLE: b = 12'sd1000;
            CH_YAW:      b = 12'sd30;
            default:     b = 12'sd15;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### design/rcss_cfg.sv
`default_nettype none

module rcss_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rcss_pkg::APB_AW-1:0]   paddr,
    input  logic [rcss_pkg::APB_DW-1:0]   pwdata,
    output logic [rcss_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output rcss_pkg::cfg_t                cfg
);
    import rcss_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[APB_AW-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_ALPHA:           cfg_next.alpha           = pwdata[ALPHA_W-1:0];
                REG_CENTER_ROLL:     cfg_next.center_roll     = pwdata[CENTER_W-1:0];
                REG_CENTER_PITCH:    cfg_next.center_pitch    = pwdata[CENTER_W-1:0];
                REG_CENTER_THROTTLE: cfg_next.center_throttle = pwdata[CENTER_W-1:0];
                REG_CENTER_YAW:      cfg_next.center_yaw      = pwdata[CENTER_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ALPHA:           prdata = APB_DW'(cfg_reg.alpha);
            REG_CENTER_ROLL:     prdata = APB_DW'(cfg_reg.center_roll);
            REG_CENTER_PITCH:    prdata = APB_DW'(cfg_reg.center_pitch);
            REG_CENTER_THROTTLE: prdata = APB_DW'(cfg_reg.center_throttle);
            REG_CENTER_YAW:      prdata = APB_DW'(cfg_reg.center_yaw);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha           <= ALPHA_RST;
            cfg_reg.center_roll     <= CENTER_ROLL_RST;
            cfg_reg.center_pitch    <= CENTER_PITCH_RST;
            cfg_reg.center_throttle <= CENTER_THROTTLE_RST;
            cfg_reg.center_yaw      <= CENTER_YAW_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### design/rcss_div.sv
`default_nettype none

module rcss_div #(
    parameter int NW = 23
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [NW-1:0]                     dividend,
    input  rcss_pkg::chan_t                   ch,
    output logic                              done,
    output logic [NW-1:0]                     quotient
);
    import rcss_pkg::*;

    // Division by a constant as a multiplication by its rounded-up reciprocal.
    // A shift of NW plus the bit count of the divisor keeps the quotient exact
    // for every dividend below 2^NW.
    localparam int     MW        = NW + 1;
    localparam int     PW        = NW + MW;
    localparam int     SH_CMD    = NW + $clog2(DIV_CMD);
    localparam int     SH_THR    = NW + $clog2(DIV_THR);
    localparam longint REC_CMD   = ((longint'(1) << SH_CMD) + longint'(DIV_CMD - 1))
                                   / longint'(DIV_CMD);
    localparam longint REC_THR   = ((longint'(1) << SH_THR) + longint'(DIV_THR - 1))
                                   / longint'(DIV_THR);

    logic [NW-1:0]  num_reg;
    logic [MW-1:0]  rec_reg;
    logic           thr_reg;
    logic           v1_reg;
    logic           done_reg;
    logic [PW-1:0]  prod_reg;
    logic [PW-1:0]  prod;

    assign prod = num_reg * rec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            done_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rec_reg <= (ch == CH_THROTTLE) ? MW'(REC_THR) : MW'(REC_CMD);
            thr_reg <= (ch == CH_THROTTLE);
        end
        if (v1_reg)
        begin
            prod_reg <= prod;
        end
    end

    assign done     = done_reg;
    assign quotient = thr_reg ? NW'(prod_reg >> SH_THR) : NW'(prod_reg >> SH_CMD);

endmodule

`default_nettype wire

### design/rcss_blend.sv
`default_nettype none

module rcss_blend #(
    parameter int SW = 19,
    parameter int AB = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [SW-1:0]             pre,
    input  logic signed [SW-1:0]             prev,
    input  logic [rcss_pkg::ALPHA_W-1:0]     alpha,
    output logic                             done,
    output logic signed [SW-1:0]             result
);
    import rcss_pkg::*;

    localparam int AW   = AB + 1;
    localparam int PW   = SW + AW + 2;
    localparam int SUMW = PW + 1;
    localparam int CMPW = (ALPHA_W > AW) ? ALPHA_W : AW;
    localparam logic [AW-1:0]          FULL = {1'b1, {AB{1'b0}}};
    localparam logic signed [SUMW-1:0] HALF = SUMW'(1) <<< (AB - 1);

    logic [AW-1:0]           a_sat;
    logic signed [AW:0]      a_s;
    logic signed [SW:0]      diff;
    logic signed [PW-1:0]    prod;
    logic signed [PW-1:0]    prod_reg;
    logic signed [SW-1:0]    pre_reg;
    logic                    v1_reg;
    logic signed [SUMW-1:0]  sum;
    logic signed [SW-1:0]    result_reg;
    logic                    done_reg;

    // s' = pre + alpha * (s - pre) / 2^AB, rounded half up.
    assign a_sat = (CMPW'(alpha) > CMPW'(FULL)) ? FULL : AW'(alpha);
    assign a_s   = $signed({1'b0, a_sat});
    assign diff  = {prev[SW-1], prev} - {pre[SW-1], pre};
    assign prod  = diff * a_s;
    assign sum   = (SUMW'(pre_reg) <<< AB) + SUMW'(prod_reg) + HALF;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            done_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod;
        pre_reg    <= pre;
        result_reg <= sum[AB+SW-1:AB];
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

### design/rc_channel_scale_smooth.sv
// Each channel passes in turn through the difference, numerator, divide, mix and blend
// steps; the reciprocal multiplier and the blend are shared by all four channels.
// A frame with pulse sum at most 100 skips these steps and goes straight to the output
// state. A new frame is taken only in the idle state, after the previous result is loaded.
// Reset: rst_n clears the smoothed values, the sequencer and the output valid, and
// loads the configuration registers with their defaults.
`default_nettype none
`include "assert_macros.svh"

module rc_channel_scale_smooth #(
    parameter int FRAC_BITS  = rcss_pkg::FRAC_BITS_DEF,
    parameter int ALPHA_BITS = rcss_pkg::ALPHA_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [rcss_pkg::APB_AW-1:0]            paddr,
    input  logic [rcss_pkg::APB_DW-1:0]            pwdata,
    output logic [rcss_pkg::APB_DW-1:0]            prdata,
    output logic                                   pready,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [rcss_pkg::WIDTH_W-1:0]           width_roll,
    input  logic [rcss_pkg::WIDTH_W-1:0]           width_pitch,
    input  logic [rcss_pkg::WIDTH_W-1:0]           width_throttle,
    input  logic [rcss_pkg::WIDTH_W-1:0]           width_yaw,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [rcss_pkg::CMD_RP_W-1:0]   roll_cmd,
    output logic signed [rcss_pkg::CMD_RP_W-1:0]   pitch_cmd,
    output logic signed [rcss_pkg::CMD_Y_W-1:0]    yaw_cmd,
    output logic [rcss_pkg::CMD_T_W-1:0]           throttle_cmd,
    output logic                                   signal_lost
);
    import rcss_pkg::*;

    localparam int SW = FRAC_BITS + 11;
    localparam int NW = FRAC_BITS + 15;
    localparam int QW = FRAC_BITS + 12;
    localparam int XW = 32;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIFF  = 3'd1;
    localparam logic [2:0] S_NUMER = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_MIX   = 3'd4;
    localparam logic [2:0] S_BLEND = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    cfg_t cfg;

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    chan_t                       ch_reg;
    chan_t                       ch_next;
    logic                        lost_reg;
    logic                        lost_next;
    logic signed [SW-1:0]        smooth_reg [4];
    logic signed [SW-1:0]        smooth_next [4];
    logic [WIDTH_W-1:0]          w_reg [4];
    logic signed [DIFF_W-1:0]    dcl_reg;
    logic signed [DIFF_W-1:0]    dcl_next;
    logic                        neg_reg;
    logic                        neg_next;
    logic signed [SW-1:0]        pre_reg;
    logic signed [SW-1:0]        pre_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic signed [CMD_RP_W-1:0]  roll_reg;
    logic signed [CMD_RP_W-1:0]  pitch_reg;
    logic signed [CMD_Y_W-1:0]   yaw_reg;
    logic [CMD_T_W-1:0]          throttle_reg;
    logic                        lost_out_reg;

    logic                        accept;
    logic                        lost_frame;
    logic [SUM_W-1:0]            width_sum;
    logic                        load_out;
    logic [WIDTH_W-1:0]          w_sel;
    logic [CENTER_W-1:0]         c_sel;
    logic signed [WIDTH_W:0]     d_full;
    logic signed [DIFF_W-1:0]    dlim;
    logic signed [DIFF_W-1:0]    dlim_n;
    logic signed [NW-1:0]        dcl_ext;
    logic signed [NW-1:0]        mul_ext;
    logic signed [NW-1:0]        n_val;
    logic [NW-1:0]               n_u;
    logic [NW-1:0]               u_val;
    logic [DIVISOR_W-1:0]        dv;
    logic                        div_start;
    logic                        div_done;
    logic [NW-1:0]               div_quo;
    logic [QW-1:0]               q_mag;
    logic signed [QW-1:0]        q_val;
    logic signed [QW-1:0]        lo_q;
    logic signed [QW-1:0]        hi_q;
    logic signed [QW-1:0]        q_cl;
    logic                        blend_start;
    logic                        blend_done;
    logic signed [SW-1:0]        blend_res;
    logic signed [XW-1:0]        sx_roll;
    logic signed [XW-1:0]        sx_pitch;
    logic signed [XW-1:0]        sx_yaw;
    logic signed [XW-1:0]        sx_throttle;

    rcss_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rcss_div #(
        .NW (NW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (u_val),
        .ch       (ch_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    rcss_blend #(
        .SW (SW),
        .AB (ALPHA_BITS)
    ) u_blend (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (blend_start),
        .pre    (pre_reg),
        .prev   (smooth_reg[ch_reg]),
        .alpha  (cfg.alpha),
        .done   (blend_done),
        .result (blend_res)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign width_sum  = SUM_W'(width_roll) + SUM_W'(width_pitch)
                      + SUM_W'(width_throttle) + SUM_W'(width_yaw);
    assign lost_frame = (width_sum <= LOST_LIMIT);
    assign load_out   = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        case (ch_reg)
            CH_ROLL:     c_sel = cfg.center_roll;
            CH_PITCH:    c_sel = cfg.center_pitch;
            CH_THROTTLE: c_sel = cfg.center_throttle;
            CH_YAW:      c_sel = cfg.center_yaw;
            default:     c_sel = cfg.center_roll;
        endcase
    end

    // Centered width, limited on both sides just past the point where the channel saturates.
    assign w_sel    = w_reg[ch_reg];
    assign d_full   = $signed({1'b0, w_sel}) - $signed({{(WIDTH_W - CENTER_W + 1){1'b0}}, c_sel});
    assign dlim     = chan_dlim(ch_reg);
    assign dlim_n   = -dlim;
    assign dcl_next = (d_full > (WIDTH_W + 1)'(dlim)) ? dlim :
                      ((d_full < (WIDTH_W + 1)'(dlim_n)) ? dlim_n : d_full[DIFF_W-1:0]);

    // Numerator with the rounding offset; negative values become ~n + d so that
    // the unsigned quotient, negated, is the floor.
    assign dv      = chan_div(ch_reg);
    assign dcl_ext = NW'(dcl_reg);
    assign mul_ext = $signed(NW'(chan_mul(ch_reg)));
    assign n_val   = ((dcl_ext * mul_ext) <<< FRAC_BITS) + $signed(NW'(dv >> 1));
    assign n_u     = n_val;
    assign u_val   = n_val[NW-1] ? (~n_u + NW'(dv)) : n_u;
    assign neg_next = n_val[NW-1];

    assign div_start   = (state_reg == S_NUMER);
    assign blend_start = (state_reg == S_MIX);

    assign q_mag = div_quo[QW-1:0];
    assign q_val = neg_reg ? $signed(QW'(0) - q_mag) : $signed(q_mag);
    assign lo_q  = QW'(chan_lo(ch_reg)) <<< FRAC_BITS;
    assign hi_q  = QW'(chan_hi(ch_reg)) <<< FRAC_BITS;
    assign q_cl  = (q_val < lo_q) ? lo_q : ((q_val > hi_q) ? hi_q : q_val);
    assign pre_next = q_cl[SW-1:0];

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        lost_next  = lost_reg;
        for (int i = 0; i < 4; i++)
        begin
            smooth_next[i] = smooth_reg[i];
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ch_next   = CH_ROLL;
                    lost_next = lost_frame;
                    if (lost_frame)
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            smooth_next[i] = '0;
                        end
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_DIFF;
                    end
                end
            end
            S_DIFF:  state_next = S_NUMER;
            S_NUMER: state_next = S_DIV;
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_MIX;
                end
            end
            S_MIX:   state_next = S_BLEND;
            S_BLEND:
            begin
                if (blend_done)
                begin
                    smooth_next[ch_reg] = blend_res;
                    if (ch_reg == CH_YAW)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = S_DIFF;
                    end
                end
            end
            S_FIN:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign sx_roll     = XW'(smooth_reg[CH_ROLL]);
    assign sx_pitch    = XW'(smooth_reg[CH_PITCH]);
    assign sx_yaw      = XW'(smooth_reg[CH_YAW]);
    assign sx_throttle = XW'(smooth_reg[CH_THROTTLE]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= CH_ROLL;
            lost_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                smooth_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            lost_reg      <= lost_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 4; i++)
            begin
                smooth_reg[i] <= smooth_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            w_reg[CH_ROLL]     <= width_roll;
            w_reg[CH_PITCH]    <= width_pitch;
            w_reg[CH_THROTTLE] <= width_throttle;
            w_reg[CH_YAW]      <= width_yaw;
        end
        if (state_reg == S_DIFF)
        begin
            dcl_reg <= dcl_next;
        end
        if (state_reg == S_NUMER)
        begin
            neg_reg <= neg_next;
        end
        if (div_done)
        begin
            pre_reg <= pre_next;
        end
        if (load_out)
        begin
            roll_reg     <= sx_roll[CMD_RP_W-1:0];
            pitch_reg    <= sx_pitch[CMD_RP_W-1:0];
            yaw_reg      <= sx_yaw[CMD_Y_W-1:0];
            throttle_reg <= sx_throttle[CMD_T_W-1:0];
            lost_out_reg <= lost_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign roll_cmd     = roll_reg;
    assign pitch_cmd    = pitch_reg;
    assign yaw_cmd      = yaw_reg;
    assign throttle_cmd = throttle_reg;
    assign signal_lost  = lost_out_reg;

    `ASSERT_SAME(a_div_done_in_wait, div_done, state_reg == S_DIV, "Divider finished outside its wait state.")
    `ASSERT_SAME(a_blend_done_in_wait, blend_done, state_reg == S_BLEND, "Blend finished outside its wait state.")
    `ASSERT_SAME(a_lost_zero, out_valid && signal_lost, roll_cmd == '0 && pitch_cmd == '0 && yaw_cmd == '0 && throttle_cmd == '0, "Lost frame gave nonzero commands.")
    `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "Block ready right after an input transfer.")

endmodule

`default_nettype wire
